FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the A-law encoder unit.
// Holds only macro definitions; expects a clock named clk and a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sdae_pkg.sv
// Shared types and constants of the stereo decimating A-law encoder.
// No dependencies; every design module imports this package.
package sdae_pkg;

  // Ping-pong buffer geometry.
  localparam int BLOCK_BYTES = 256;
  localparam int POS_W       = $clog2(2 * BLOCK_BYTES);

  // Sample and code widths.
  localparam int SAMPLE_W = 16;
  localparam int FACTOR_W = 4;
  localparam int CODE_W   = 8;

  // A-law constants.
  localparam logic [14:0]       ALAW_CLAMP = 15'd32635;
  localparam logic [CODE_W-1:0] ALAW_XOR   = 8'hD5;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd6;
  localparam logic                REG_DECIMATION = 1'b0;

  // Kept sample held in stage one, with its buffer tags.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mono;
    logic                       last;
    logic                       half;
  } kept_t;

  // Status of the front stage, seen by the top level.
  typedef struct packed {
    logic                valid;
    logic                load;
    logic [FACTOR_W-1:0] phase;
    logic [POS_W-1:0]    fill_pos;
  } front_status_t;

endpackage

FILE: design/sdae_cfg_regs.sv
// APB-style register file holding the decimation factor.
// Depends on sdae_pkg for the address, data and factor widths.
module sdae_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdae_pkg::ADDR_W-1:0]   paddr,
  input  logic [sdae_pkg::DATA_W-1:0]   pwdata,
  output logic [sdae_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [sdae_pkg::FACTOR_W-1:0] decimation_factor
);
  import sdae_pkg::*;

  logic wr_en;
  logic hit_decim;

  // Word index is the address above the byte offset.
  assign hit_decim = (paddr[ADDR_W-1:2] == REG_DECIMATION);
  assign wr_en     = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Factor register; writes to other addresses are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_factor <= FACTOR_RESET;
    end else if (wr_en && hit_decim) begin
      decimation_factor <= pwdata[FACTOR_W-1:0];
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    if (hit_decim) begin
      prdata = DATA_W'(decimation_factor);
    end
  end

endmodule

FILE: design/sdae_front.sv
// Input stage: decimation phase, stereo-to-mono average, buffer position tags.
// Depends on sdae_pkg for the kept_t and front_status_t types.
module sdae_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [sdae_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [sdae_pkg::SAMPLE_W-1:0] right_in,
  input  logic [sdae_pkg::FACTOR_W-1:0] decimation_factor,
  input  logic                          advance,
  output sdae_pkg::kept_t               kept,
  output sdae_pkg::front_status_t       status
);
  import sdae_pkg::*;

  logic                       accept;
  logic                       load;
  logic                       s1_valid;
  logic [FACTOR_W-1:0]        phase;
  logic [FACTOR_W-1:0]        phase_inc;
  logic [FACTOR_W-1:0]        phase_next;
  logic [POS_W-1:0]           fill_pos;
  logic [POS_W-1:0]           fill_pos_next;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W:0]   sum_adj;
  kept_t                      kept_next;

  // Stage one takes a request when empty or when it drains this cycle.
  assign sample_stall = s1_valid && !advance;
  assign accept       = sample_valid && !sample_stall;
  assign load         = accept && (phase == '0);

  // Phase counter returns to zero once it reaches the factor.
  always_comb begin
    phase_inc  = phase + FACTOR_W'(1);
    phase_next = (phase_inc >= decimation_factor) ? '0 : phase_inc;
  end

  // Average with truncation toward zero: bias negative sums by one.
  always_comb begin
    sum     = {left_in[SAMPLE_W-1], left_in} + {right_in[SAMPLE_W-1], right_in};
    sum_adj = sum + (SAMPLE_W+1)'(sum[SAMPLE_W]);
  end

  // Buffer tags for the byte about to be stored.
  always_comb begin
    kept_next.mono = sum_adj[SAMPLE_W:1];
    kept_next.last = (fill_pos == POS_W'(BLOCK_BYTES - 1)) ||
                     (fill_pos == POS_W'(2 * BLOCK_BYTES - 1));
    kept_next.half = (fill_pos >= POS_W'(BLOCK_BYTES));
    fill_pos_next  = (fill_pos == POS_W'(2 * BLOCK_BYTES - 1)) ?
                     '0 : fill_pos + POS_W'(1);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      fill_pos <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next;
      end
      if (load) begin
        fill_pos <= fill_pos_next;
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (load) begin
      kept <= kept_next;
    end
  end

  assign status.valid    = s1_valid;
  assign status.load     = load;
  assign status.phase    = phase;
  assign status.fill_pos = fill_pos;

endmodule

FILE: design/sdae_encoder.sv
// G.711 A-law compressor for one signed 16-bit mono sample.
// Depends on sdae_pkg for the widths and the A-law constants.
module sdae_encoder (
  input  logic signed [sdae_pkg::SAMPLE_W-1:0] mono,
  output logic [sdae_pkg::CODE_W-1:0]          code
);
  import sdae_pkg::*;

  logic        sign;
  logic [15:0] mag_raw;
  logic [14:0] mag;
  logic [2:0]  seg;
  logic [3:0]  shamt;
  logic [14:0] shifted;
  logic [3:0]  mant;

  // Sign and magnitude; the most negative value saturates with the clamp.
  always_comb begin
    sign    = mono[SAMPLE_W-1];
    mag_raw = sign ? (16'd0 - 16'(mono)) : 16'(mono);
    mag     = (mag_raw > 16'(ALAW_CLAMP)) ? ALAW_CLAMP : mag_raw[14:0];
  end

  // Segment from the leading one of bits 14 down to 8.
  always_comb begin
    seg = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (mag[i + 7]) begin
        seg = 3'(i);
      end
    end
  end

  // Four mantissa bits below the leading one; bits 7 down to 4 in segment zero.
  always_comb begin
    shamt   = (seg == 3'd0) ? 4'd4 : (4'(seg) + 4'd3);
    shifted = mag >> shamt;
    mant    = shifted[3:0];
    code    = {sign, seg, mant} ^ ALAW_XOR;
  end

endmodule

FILE: design/sdae_out_stage.sv
// Result register for the encoded byte and its buffer tags.
// Depends on sdae_pkg for the kept_t type and the code width.
module sdae_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s1_valid,
  input  sdae_pkg::kept_t             kept,
  input  logic [sdae_pkg::CODE_W-1:0] code_in,
  output logic                        advance,
  output logic                        code_valid,
  input  logic                        code_stall,
  output logic [sdae_pkg::CODE_W-1:0] alaw_code,
  output logic                        block_last,
  output logic                        block_half
);
  import sdae_pkg::*;

  // Register moves whenever it is empty or its request is taken.
  assign advance = !code_valid || !code_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (advance) begin
      code_valid <= s1_valid;
    end
  end

  // Payload follows stage one whenever the register moves with a stage one request.
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      alaw_code  <= code_in;
      block_last <= kept.last;
      block_half <= kept.half;
    end
  end

endmodule

FILE: design/stereo_decimating_alaw_encoder_unit.sv
// Top level of the stereo decimating A-law encoder.
// Depends on sdae_pkg, assert_macros.svh and the sdae_* submodules.
//
//   channel   direction  handshake                   payload
//   sample    in         sample_valid/sample_stall   left_in, right_in
//   code      out        code_valid/code_stall       alaw_code, block_last, block_half
//   config    in         APB psel/penable/pready     paddr, pwdata, prdata
//
// One stereo pair may be accepted every cycle while sample_stall is low; a kept
// pair passes the stage one register, then the result register, to show as a byte.
// Synchronous reset empties both stages, clears the phase and fill counters and
// sets the factor to 6. A stall on the code side holds the result register, and
// stage one, if empty, still takes one more kept request before sample_stall rises.
module stereo_decimating_alaw_encoder_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [sdae_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [sdae_pkg::SAMPLE_W-1:0] right_in,
  output logic                                 code_valid,
  input  logic                                 code_stall,
  output logic [sdae_pkg::CODE_W-1:0]          alaw_code,
  output logic                                 block_last,
  output logic                                 block_half,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sdae_pkg::ADDR_W-1:0]          paddr,
  input  logic [sdae_pkg::DATA_W-1:0]          pwdata,
  output logic [sdae_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import sdae_pkg::*;

  logic [FACTOR_W-1:0] decimation_factor;
  logic                advance;
  logic [CODE_W-1:0]   code_enc;
  kept_t               kept;
  front_status_t       status;

  // Configuration registers.
  sdae_cfg_regs u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .decimation_factor (decimation_factor)
  );

  // Decimation, averaging and buffer tagging.
  sdae_front u_front (
    .clk               (clk),
    .rst               (rst),
    .sample_valid      (sample_valid),
    .sample_stall      (sample_stall),
    .left_in           (left_in),
    .right_in          (right_in),
    .decimation_factor (decimation_factor),
    .advance           (advance),
    .kept              (kept),
    .status            (status)
  );

  // A-law compression between the two registers.
  sdae_encoder u_enc (
    .mono (kept.mono),
    .code (code_enc)
  );

  // Result register.
  sdae_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (status.valid),
    .kept       (kept),
    .code_in    (code_enc),
    .advance    (advance),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .alaw_code  (alaw_code),
    .block_last (block_last),
    .block_half (block_half)
  );

`include "assert_macros.svh"

  // The input side only stalls while stage one holds a request.
  `ASSERT_SAME(a_stall_needs_s1, sample_stall, status.valid && code_valid,
    "sample_stall raised without a blocked request")

  // A phase at or beyond the factor folds back to zero on the next request.
  `ASSERT_NEXT(a_phase_fold,
    sample_valid && !sample_stall && (status.phase >= decimation_factor),
    status.phase == '0, "phase counter did not fold back")

  // Every kept request moves the fill position.
  `ASSERT_NEXT(a_fill_moves, status.load,
    status.fill_pos != $past(status.fill_pos), "fill position did not advance")

  // A stalled result keeps stage one from being lost.
  `ASSERT_NEXT(a_s1_kept, status.valid && code_valid && code_stall,
    status.valid, "stage one dropped a request under stall")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the stereo decimating A-law encoder unit.
// Depends on sdae_pkg and the RTL under stereo_decimating_alaw_encoder_unit.
// Predicts each byte at request time and checks every output byte in order.
`timescale 1ns / 100ps

module testbench;
  import sdae_pkg::*;

  // Register index that the block does not implement.
  localparam int REG_UNUSED  = 1;
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_ITEMS  = 230;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
    logic              half;
  } alaw_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] left_in  = '0;
  logic signed [SAMPLE_W-1:0] right_in = '0;
  logic                       code_valid;
  logic                       code_stall = 1'b0;
  logic [CODE_W-1:0]          alaw_code;
  logic                       block_last;
  logic                       block_half;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [ADDR_W-1:0]          paddr   = '0;
  logic [DATA_W-1:0]          pwdata  = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  // Predictor state: a copy of the register and the two counters.
  logic [FACTOR_W-1:0] factor_q = FACTOR_RESET;
  logic [FACTOR_W-1:0] phase_q  = '0;
  logic [POS_W-1:0]    fill_q   = '0;

  alaw_byte_t pending_codes[$];

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;
  int mismatches      = 0;
  int pairs_sent      = 0;
  int codes_checked   = 0;
  int block_ends      = 0;
  int factor_writes   = 0;

  stereo_decimating_alaw_encoder_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .left_in      (left_in),
    .right_in     (right_in),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .alaw_code    (alaw_code),
    .block_last   (block_last),
    .block_half   (block_half),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // A-law byte of one mono sample: sign, clamped magnitude, segment, mantissa.
  function automatic logic [CODE_W-1:0] alaw_of(input int mono);
    logic       sign;
    int         mag;
    int         seg;
    logic [3:0] mant;
    sign = (mono < 0);
    mag  = sign ? -mono : mono;
    if (mag > int'(ALAW_CLAMP)) mag = int'(ALAW_CLAMP);
    seg = 0;
    for (int b = 14; b >= 8; b--) begin
      if (seg == 0 && mag[b]) seg = b - 7;
    end
    mant = 4'(((seg == 0) ? (mag >> 4) : (mag >> (seg + 3))) & 15);
    return {sign, 3'(seg), mant} ^ ALAW_XOR;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  // Advances the decimation phase and, for a kept pair, queues its byte.
  task automatic predict_pair(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r);
    alaw_byte_t item;
    int         nxt;
    if (phase_q == '0) begin
      item.code = alaw_of((int'(l) + int'(r)) / 2);
      item.last = (((int'(fill_q) + 1) % BLOCK_BYTES) == 0);
      item.half = (int'(fill_q) >= BLOCK_BYTES);
      pending_codes.push_back(item);
      fill_q = (int'(fill_q) == 2 * BLOCK_BYTES - 1) ? '0 : fill_q + 1'b1;
    end
    nxt = (int'(phase_q) + 1) % (2 ** FACTOR_W);
    if (nxt >= int'(factor_q)) nxt = 0;
    phase_q = FACTOR_W'(nxt);
  endtask

  // Sends one stereo request, with an optional idle gap in front of it.
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    left_in      <= l;
    right_in     <= r;
    do @(posedge clk); while (sample_stall);
    predict_pair(l, r);
    pairs_sent++;
  endtask

  // Stops sending, waits for every expected byte, then lets the pipeline settle.
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write followed by a read back of the decimation register.
  task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == int'(REG_DECIMATION)) begin
      factor_q = value[FACTOR_W-1:0];
      factor_writes++;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(int'(REG_DECIMATION) * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", DATA_W'(factor_q), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random sample biased toward extremes and small magnitudes.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 3))
          0: s = 16'sh8000;
          1: s = 16'sh7FFF;
          2: s = '0;
          default: s = -16'sd1;
        endcase
      end
      1, 2: begin
        s = SAMPLE_W'(16'($urandom) >> $urandom_range(1, 15));
        if ($urandom_range(0, 1) == 1) s = -s;
      end
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  task automatic send_random_pair();
    logic signed [SAMPLE_W-1:0] l;
    l = rand_sample();
    send_pair(l, ($urandom_range(0, 2) == 0) ? l : rand_sample());
  endtask

  // Output checker: one expected byte per accepted output request.
  always @(posedge clk) begin
    alaw_byte_t want;
    if (!rst && code_valid && !code_stall) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte, expected none, actual 0x%0h", $time, alaw_code);
      end else begin
        want = pending_codes.pop_front();
        check_field("alaw_code", want.code, alaw_code);
        check_field("block_last", want.last, block_last);
        check_field("block_half", want.half, block_half);
        codes_checked++;
        if (block_last) block_ends++;
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      code_stall <= 1'b0;
    end else if (hold_left > 0) begin
      code_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      code_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: ends the run after too many cycles without any accepted request.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (code_valid && !code_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired with %0d bytes outstanding", $time,
               pending_codes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Segment edges, clamp, truncation toward zero and the most negative mean.
  task automatic test_encoding();
    int lefts[13]  = '{-32768, 32767, 32767, -1, -1, -32768, 15, 16, 255, 256,
                       16384, 32636, -4096};
    int rights[13] = '{-32768, 32767, -32768, -2, 0, -32767, 15, 16, 255, 256,
                       16384, 32636, -4096};
    write_reg(REG_UNUSED, 32'd9);
    write_reg(REG_DECIMATION, 32'd1);
    for (int i = 0; i < 13; i++) send_pair(SAMPLE_W'(lefts[i]), SAMPLE_W'(rights[i]));
    wait_idle();
  endtask

  // A factor of zero keeps every pair.
  task automatic test_factor_zero();
    write_reg(REG_DECIMATION, 32'd0);
    repeat (3) send_random_pair();
    wait_idle();
  endtask

  // Lowering the factor while the phase sits past the new value.
  task automatic test_factor_lowered();
    write_reg(REG_DECIMATION, 32'd15);
    repeat (5) send_random_pair();
    wait_idle();
    write_reg(REG_DECIMATION, 32'd3);
    repeat (4) send_random_pair();
    wait_idle();
  endtask

  // Long receiver hold-off fills the pipeline; then the sender pauses to drain.
  task automatic test_backpressure();
    write_reg(REG_DECIMATION, 32'd1);
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_left       = 200;
    repeat (30) send_random_pair();
    sample_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    stall_pct = 52;
    repeat (30) send_random_pair();
    wait_idle();
  endtask

  // Random traffic over several factors and the four idling patterns.
  task automatic test_random_traffic();
    int idle_by_mode[4]  = '{0, 52, 0, 37};
    int stall_by_mode[4] = '{0, 0, 52, 37};
    int factors[8];
    factors = '{1, 15, 0, 6, $urandom_range(2, 14), 1, 15, $urandom_range(0, 15)};
    for (int seg = 0; seg < 8; seg++) begin
      write_reg(REG_DECIMATION, DATA_W'(factors[seg]));
      sender_idle_pct = idle_by_mode[seg / 2];
      stall_pct       = stall_by_mode[seg / 2];
      repeat (RAND_ITEMS) send_random_pair();
      wait_idle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_encoding();
    test_factor_zero();
    test_factor_lowered();
    test_backpressure();
    test_random_traffic();
    if (pending_codes.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected bytes never arrived", $time, pending_codes.size());
    end
    $display("Sent %0d stereo pairs and checked %0d A-law bytes, %0d of them block ends,",
             pairs_sent, codes_checked, block_ends);
    $display("over %0d decimation settings including 0, 1 and 15, with idling and stalls.",
             factor_writes);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
